[hw/rtl/nzda_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// nzda_pkg
// Types, character codes and number decoding shared by the ZDA parser files.
// ============================================================================
package nzda_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [6:0] t_val;
    typedef logic [2:0] t_tok;
    typedef logic [3:0][7:0] t_num_chars;

    typedef struct packed {
        t_val hours;
        t_val minutes;
        t_val seconds;
        t_val day;
        t_val month;
        t_val year;
        logic time_valid;
        logic date_valid;
    } t_zda_result;

    localparam int unsigned PREFIX_LEN = 7;

    localparam t_byte CH_NUL   = 8'h00;
    localparam t_byte CH_TAB   = 8'h09;
    localparam t_byte CH_LF    = 8'h0A;
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_DOLLAR = 8'h24;
    localparam t_byte CH_PLUS  = 8'h2B;
    localparam t_byte CH_COMMA = 8'h2C;
    localparam t_byte CH_MINUS = 8'h2D;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_NINE  = 8'h39;

    // token order after the sentence prefix
    localparam t_tok TOK_TIME  = 3'd0;
    localparam t_tok TOK_DAY   = 3'd1;
    localparam t_tok TOK_MONTH = 3'd2;
    localparam t_tok TOK_YEAR  = 3'd3;
    localparam t_tok TOK_DONE  = 3'd4;

    localparam logic [2:0] TOK_CHARS_MAX = 3'd6;
    localparam logic [2:0] TIME_LEN      = 3'd6;
    localparam logic [2:0] FIELD_LEN     = 3'd2;
    localparam logic [2:0] YEAR_LEN      = 3'd4;

    function automatic t_byte f_prefix_char(input logic [2:0] pos);
        t_byte ch;
        case (pos)
            3'd0: ch = CH_DOLLAR;
            3'd1: ch = 8'h47;  // G
            3'd2: ch = 8'h4E;  // N
            3'd3: ch = 8'h5A;  // Z
            3'd4: ch = 8'h44;  // D
            3'd5: ch = 8'h41;  // A
            default: ch = CH_COMMA;
        endcase
        return ch;
    endfunction

    function automatic logic f_is_ws(input t_byte ch);
        return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    endfunction

    function automatic logic f_is_digit(input t_byte ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    // atoi over the first len characters; returns the value modulo 100,
    // i.e. the last two digits read. Negative numbers give zero.
    function automatic t_val f_atoi_mod100(input t_num_chars ch, input logic [2:0] len);
        logic       skip;
        logic       done;
        logic       neg;
        logic [3:0] last;
        t_val       val;
        skip = 1'b1;
        done = 1'b0;
        neg  = 1'b0;
        last = 4'd0;
        val  = '0;
        for (int i = 0; i < 4; i++) begin
            if ((3'(i) < len) && !done) begin
                if (skip && f_is_ws(ch[i])) begin
                    skip = 1'b1;
                end else if (skip && ((ch[i] == CH_PLUS) || (ch[i] == CH_MINUS))) begin
                    skip = 1'b0;
                    neg  = (ch[i] == CH_MINUS);
                end else if (f_is_digit(ch[i])) begin
                    skip = 1'b0;
                    val  = 7'(last) * 7'd10 + 7'(ch[i][3:0]);
                    last = ch[i][3:0];
                end else begin
                    done = 1'b1;
                end
            end
        end
        return neg ? '0 : val;
    endfunction

endpackage

[hw/rtl/nzda_byte_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// nzda_byte_if
// Valid/ready channel carrying one received character per transfer.
// ============================================================================
interface nzda_byte_if;
    import nzda_pkg::*;

    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[hw/rtl/nzda_result_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// nzda_result_if
// Valid/ready channel carrying one decoded time/date result per transfer.
// ============================================================================
interface nzda_result_if;
    import nzda_pkg::*;

    logic valid;
    logic ready;
    t_val hours;
    t_val minutes;
    t_val seconds;
    t_val day;
    t_val month;
    t_val year;
    logic time_valid;
    logic date_valid;

    modport source (
        output valid, output hours, output minutes, output seconds,
        output day, output month, output year, output time_valid,
        output date_valid, input ready
    );
    modport sink (
        input valid, input hours, input minutes, input seconds,
        input day, input month, input year, input time_valid,
        input date_valid, output ready
    );
endinterface

[hw/rtl/nzda_in_stage.sv]
`timescale 1ns / 1ps
// ============================================================================
// nzda_in_stage
// Input register: holds one received byte until the parser consumes it.
// ============================================================================
module nzda_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  nzda_pkg::t_byte i_byte,
    output logic           o_ready,
    input  logic           i_advance,
    output logic           o_valid,
    output nzda_pkg::t_byte o_byte
);
    import nzda_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_byte r_byte;
    logic  w_take;

    assign o_ready = !r_valid || i_advance;
    assign w_take  = i_valid && o_ready;
    assign n_valid = w_take || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

[hw/rtl/nzda_parse_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// nzda_parse_core
// Line framing, prefix match, tokenizing, decode; one byte per enabled cycle.
// ============================================================================
module nzda_parse_core #(
    parameter int unsigned LINE_CAPACITY = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  nzda_pkg::t_byte       i_byte,
    output logic                  o_res_vld,
    output nzda_pkg::t_zda_result o_result
);
    import nzda_pkg::*;

    localparam int unsigned LC_W = $clog2(LINE_CAPACITY + 1);

    logic [LC_W-1:0] r_line_count, n_line_count;
    logic            r_prefix_match, n_prefix_match;
    t_tok            r_token_index, n_token_index;
    logic [2:0]      r_token_chars, n_token_chars;
    logic            r_text_ended, n_text_ended;
    logic [5:0][7:0] r_tok_buf, n_tok_buf;

    t_val r_p_hour, n_p_hour;
    t_val r_p_min,  n_p_min;
    t_val r_p_sec,  n_p_sec;
    t_val r_p_day,  n_p_day;
    t_val r_p_mon,  n_p_mon;
    t_val r_p_year, n_p_year;
    logic r_ok_time, n_ok_time;
    logic r_ok_day,  n_ok_day;
    logic r_ok_mon,  n_ok_mon;
    logic r_ok_year, n_ok_year;

    t_val r_hour, n_hour;
    t_val r_min,  n_min;
    t_val r_sec,  n_sec;
    t_val r_day,  n_day;
    t_val r_mon,  n_mon;
    t_val r_year, n_year;

    t_val w_a_hour, w_a_min, w_a_sec, w_a_day, w_a_year;
    logic w_fin_time, w_fin_day, w_fin_mon, w_fin_year;
    logic w_eol;
    logic w_do_fin;
    logic w_date_ok;

    // candidate values of the token now being collected
    assign w_a_hour = f_atoi_mod100({CH_NUL, CH_NUL, r_tok_buf[1], r_tok_buf[0]}, FIELD_LEN);
    assign w_a_min  = f_atoi_mod100({CH_NUL, CH_NUL, r_tok_buf[3], r_tok_buf[2]}, FIELD_LEN);
    assign w_a_sec  = f_atoi_mod100({CH_NUL, CH_NUL, r_tok_buf[5], r_tok_buf[4]}, FIELD_LEN);
    assign w_a_day  = f_atoi_mod100({CH_NUL, CH_NUL, r_tok_buf[1], r_tok_buf[0]}, FIELD_LEN);
    assign w_a_year = f_atoi_mod100(
        {r_tok_buf[3], r_tok_buf[2], r_tok_buf[1], r_tok_buf[0]}, YEAR_LEN);

    assign w_fin_time = (r_token_index == TOK_TIME)  && (r_token_chars >= TIME_LEN);
    assign w_fin_day  = (r_token_index == TOK_DAY)   && (r_token_chars >= FIELD_LEN);
    assign w_fin_mon  = (r_token_index == TOK_MONTH) && (r_token_chars >= FIELD_LEN);
    assign w_fin_year = (r_token_index == TOK_YEAR)  && (r_token_chars >= YEAR_LEN);

    assign w_eol = (i_byte == CH_CR) || (i_byte == CH_LF);

    always_comb begin
        n_line_count   = r_line_count;
        n_prefix_match = r_prefix_match;
        n_token_index  = r_token_index;
        n_token_chars  = r_token_chars;
        n_text_ended   = r_text_ended;
        n_tok_buf      = r_tok_buf;
        n_p_hour  = r_p_hour;
        n_p_min   = r_p_min;
        n_p_sec   = r_p_sec;
        n_p_day   = r_p_day;
        n_p_mon   = r_p_mon;
        n_p_year  = r_p_year;
        n_ok_time = r_ok_time;
        n_ok_day  = r_ok_day;
        n_ok_mon  = r_ok_mon;
        n_ok_year = r_ok_year;
        n_hour = r_hour;
        n_min  = r_min;
        n_sec  = r_sec;
        n_day  = r_day;
        n_mon  = r_mon;
        n_year = r_year;
        w_do_fin  = 1'b0;
        w_date_ok = 1'b0;
        o_res_vld = 1'b0;

        if (i_en) begin
            if (w_eol) begin
                if (r_line_count != '0) begin
                    if (r_prefix_match && (r_line_count >= LC_W'(PREFIX_LEN))) begin
                        w_do_fin = !r_text_ended && (r_token_chars != '0);
                    end
                    n_line_count = '0;
                end
            end else if ((r_line_count != '0) || (i_byte == CH_DOLLAR)) begin
                if ((r_line_count == '0) || (r_line_count >= LC_W'(LINE_CAPACITY))) begin
                    // new line; a byte past capacity starts it even if not '$'
                    n_line_count   = LC_W'(1);
                    n_prefix_match = (i_byte == CH_DOLLAR);
                    n_token_index  = TOK_TIME;
                    n_token_chars  = '0;
                    n_text_ended   = 1'b0;
                    n_ok_time      = 1'b0;
                    n_ok_day       = 1'b0;
                    n_ok_mon       = 1'b0;
                    n_ok_year      = 1'b0;
                end else begin
                    n_line_count = r_line_count + LC_W'(1);
                    if (r_line_count < LC_W'(PREFIX_LEN)) begin
                        if (i_byte != f_prefix_char(r_line_count[2:0])) begin
                            n_prefix_match = 1'b0;
                        end
                    end else if (r_prefix_match && !r_text_ended) begin
                        if ((i_byte == CH_NUL) || (i_byte == CH_COMMA)) begin
                            if (i_byte == CH_NUL) begin
                                n_text_ended = 1'b1;
                            end
                            w_do_fin = (r_token_chars != '0);
                        end else begin
                            if (r_token_chars < TOK_CHARS_MAX) begin
                                n_tok_buf[r_token_chars] = i_byte;
                                n_token_chars = r_token_chars + 3'd1;
                            end
                        end
                    end
                end
            end
        end

        if (w_do_fin) begin
            if (w_fin_time) begin
                n_p_hour  = w_a_hour;
                n_p_min   = w_a_min;
                n_p_sec   = w_a_sec;
                n_ok_time = 1'b1;
            end
            if (w_fin_day) begin
                n_p_day  = w_a_day;
                n_ok_day = 1'b1;
            end
            if (w_fin_mon) begin
                n_p_mon  = w_a_day;
                n_ok_mon = 1'b1;
            end
            if (w_fin_year) begin
                n_p_year  = w_a_year;
                n_ok_year = 1'b1;
            end
            if (r_token_index < TOK_DONE) begin
                n_token_index = r_token_index + 3'd1;
            end
            n_token_chars = '0;
        end

        // end of a matching line: commit held values and report
        if (i_en && w_eol && (r_line_count != '0) && r_prefix_match
                && (r_line_count >= LC_W'(PREFIX_LEN))) begin
            if (n_ok_time) begin
                n_hour = n_p_hour;
                n_min  = n_p_min;
                n_sec  = n_p_sec;
            end
            if (n_ok_day) begin
                n_day = n_p_day;
            end
            if (n_ok_mon) begin
                n_mon = n_p_mon;
            end
            if (n_ok_year) begin
                n_year = n_p_year;
            end
            w_date_ok = n_ok_day && n_ok_mon && n_ok_year;
            o_res_vld = n_ok_time || w_date_ok;
        end

        o_result.hours      = n_hour;
        o_result.minutes    = n_min;
        o_result.seconds    = n_sec;
        o_result.day        = n_day;
        o_result.month      = n_mon;
        o_result.year       = n_year;
        o_result.time_valid = n_ok_time;
        o_result.date_valid = w_date_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count   <= '0;
            r_prefix_match <= 1'b1;
            r_token_index  <= TOK_TIME;
            r_token_chars  <= '0;
            r_text_ended   <= 1'b0;
            r_ok_time      <= 1'b0;
            r_ok_day       <= 1'b0;
            r_ok_mon       <= 1'b0;
            r_ok_year      <= 1'b0;
            r_hour         <= '0;
            r_min          <= '0;
            r_sec          <= '0;
            r_day          <= '0;
            r_mon          <= '0;
            r_year         <= '0;
        end else begin
            r_line_count   <= n_line_count;
            r_prefix_match <= n_prefix_match;
            r_token_index  <= n_token_index;
            r_token_chars  <= n_token_chars;
            r_text_ended   <= n_text_ended;
            r_ok_time      <= n_ok_time;
            r_ok_day       <= n_ok_day;
            r_ok_mon       <= n_ok_mon;
            r_ok_year      <= n_ok_year;
            r_hour         <= n_hour;
            r_min          <= n_min;
            r_sec          <= n_sec;
            r_day          <= n_day;
            r_mon          <= n_mon;
            r_year         <= n_year;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_buf <= n_tok_buf;
        r_p_hour  <= n_p_hour;
        r_p_min   <= n_p_min;
        r_p_sec   <= n_p_sec;
        r_p_day   <= n_p_day;
        r_p_mon   <= n_p_mon;
        r_p_year  <= n_p_year;
    end

`ifndef NO_ASSERTIONS
    a_line_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_count <= LC_W'(LINE_CAPACITY))
        else $error("line count above capacity");

    a_tok_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_token_index <= TOK_DONE) && (r_token_chars <= TOK_CHARS_MAX))
        else $error("token counters past saturation");

    a_res_on_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> (i_en && r_prefix_match && (r_line_count >= LC_W'(PREFIX_LEN))
                       && ((i_byte == CH_CR) || (i_byte == CH_LF))))
        else $error("result outside end of a matching line");

    a_res_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> (o_result.time_valid || o_result.date_valid))
        else $error("result with neither time nor date");

    a_line_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (r_line_count != '0) && ((i_byte == CH_CR) || (i_byte == CH_LF)))
        |=> (r_line_count == '0))
        else $error("line not closed by CR/LF");
`endif
endmodule

[hw/rtl/nzda_out_stage.sv]
`timescale 1ns / 1ps
// ============================================================================
// nzda_out_stage
// Result register: holds one result until the receiver takes it.
// ============================================================================
module nzda_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  nzda_pkg::t_zda_result i_result,
    output logic                  o_free,
    output logic                  o_valid,
    input  logic                  i_ready,
    output nzda_pkg::t_zda_result o_result
);
    import nzda_pkg::*;

    logic        r_valid;
    logic        n_valid;
    t_zda_result r_result;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

[hw/rtl/nmea_zda_time_date_parser_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// nmea_zda_time_date_parser_unit
// Frames GPS serial bytes into lines and decodes $GNZDA time and date.
// ============================================================================
// Usage:
//   i_rx carries one received character per transfer. Lines open on '$' and
//   close on CR or LF; a $GNZDA line that yields a time (hhmmss) or a full
//   date (dd, mm, yyyy) produces one transfer on o_res, with the held time,
//   date, year modulo 100 and the two validity flags. Other lines, and bytes
//   between lines, produce nothing.
//   A closing CR/LF passes through the input register and one parser update
//   into the result register before its result shows on o_res.
//   Throughput: one byte per cycle while o_res is not stalled; the parser
//   update between the two registers is combinational.
//   Reset (i_rst_n low, synchronous) empties both registers, drops any
//   partial line and clears the held time and date to zero.
//   When o_res is stalled with a result waiting, the parser does not
//   advance until the result register frees; one more byte is held in the
//   input register, after which i_rx.ready goes low.
// ============================================================================
module nmea_zda_time_date_parser_unit #(
    parameter int unsigned LINE_CAPACITY = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nzda_byte_if.sink     i_rx,
    nzda_result_if.source o_res
);
    import nzda_pkg::*;

    logic        w_in_valid;
    t_byte       w_in_byte;
    logic        w_out_free;
    logic        w_advance;
    logic        w_res_vld;
    t_zda_result w_core_result;
    t_zda_result w_out_result;

    assign w_advance = w_in_valid && w_out_free;

    nzda_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx.valid),
        .i_byte    (i_rx.rx_byte),
        .o_ready   (i_rx.ready),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_byte    (w_in_byte)
    );

    nzda_parse_core #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_parse_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_advance),
        .i_byte    (w_in_byte),
        .o_res_vld (w_res_vld),
        .o_result  (w_core_result)
    );

    nzda_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_res_vld),
        .i_result (w_core_result),
        .o_free   (w_out_free),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_result (w_out_result)
    );

    assign o_res.hours      = w_out_result.hours;
    assign o_res.minutes    = w_out_result.minutes;
    assign o_res.seconds    = w_out_result.seconds;
    assign o_res.day        = w_out_result.day;
    assign o_res.month      = w_out_result.month;
    assign o_res.year       = w_out_result.year;
    assign o_res.time_valid = w_out_result.time_valid;
    assign o_res.date_valid = w_out_result.date_valid;
endmodule
